FILE: rtl/state_variable_filter_assert.svh
// Assertion macros for the state-variable filter.
`ifndef STATE_VARIABLE_FILTER_ASSERT_SVH
`define STATE_VARIABLE_FILTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SVF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("svf check failed");

// Next-cycle implication, checked out of reset.
`define SVF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("svf check failed");

`endif

FILE: rtl/svf_pkg.sv
// Types, constants and arithmetic helpers for the state-variable filter.
`default_nettype none
package svf_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int STATE_W   = 32;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 24;
  localparam int OPND_W    = STATE_W + 1;
  localparam int ACC_W     = COEF_W + OPND_W + 3;
  localparam int RND_W     = ACC_W - COEF_FRAC;
  localparam int EXT_W     = RND_W + 1;
  localparam int BIT_CNT_W = $clog2(COEF_W);
  localparam int CFG_IDX_W = 3;
  localparam int PROD_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A1   = 3'd0,
    REG_COEF_A2   = 3'd1,
    REG_COEF_A3   = 3'd2,
    REG_MIX_INPUT = 3'd3,
    REG_MIX_BAND  = 3'd4,
    REG_MIX_LOW   = 3'd5
  } svf_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_RUN,
    ST_V1,
    ST_V2,
    ST_OUT
  } svf_state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_last_in;
  } svf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_last_out;
  } svf_out_t;

  typedef struct packed {
    logic start;
    logic clear;
  } svf_mac_ctrl_t;

  localparam logic signed [COEF_W-1:0] MIX_INPUT_RST = COEF_W'(1) <<< COEF_FRAC;

  // Round to sample fraction bits, half toward plus infinity.
  function automatic logic signed [EXT_W-1:0] round_acc(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = acc + (ACC_W'(1) <<< (COEF_FRAC - 1));
    return EXT_W'(t >>> COEF_FRAC);
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [EXT_W-1:0] x);
    if (x[EXT_W-1:STATE_W-1] == {(EXT_W-STATE_W+1){x[EXT_W-1]}}) begin
      return x[STATE_W-1:0];
    end
    return {x[EXT_W-1], {(STATE_W-1){~x[EXT_W-1]}}};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [EXT_W-1:0] x);
    if (x[EXT_W-1:SAMPLE_W-1] == {(EXT_W-SAMPLE_W+1){x[EXT_W-1]}}) begin
      return x[SAMPLE_W-1:0];
    end
    return {x[EXT_W-1], {(SAMPLE_W-1){~x[EXT_W-1]}}};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/svf_smac.sv
// Bit-serial multiply-accumulate: one coefficient bit per cycle.
`default_nettype none
module svf_smac (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire svf_pkg::svf_mac_ctrl_t              ctrl_i,
  input  wire logic signed [svf_pkg::COEF_W-1:0]   coef_i,
  input  wire logic signed [svf_pkg::OPND_W-1:0]   opnd_i,
  output logic                                     busy_o,
  output logic signed [svf_pkg::ACC_W-1:0]         acc_o
);

  logic                                   busy_q, busy_d;
  logic [svf_pkg::BIT_CNT_W-1:0]          cnt_q, cnt_d;
  logic [svf_pkg::COEF_W-1:0]             mplier_q, mplier_d;
  logic signed [svf_pkg::ACC_W-1:0]       mcand_q, mcand_d;
  logic signed [svf_pkg::ACC_W-1:0]       acc_q, acc_d;

  always_comb begin
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    mplier_d = mplier_q;
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    if (ctrl_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      mplier_d = coef_i;
      mcand_d  = svf_pkg::ACC_W'(opnd_i);
      if (ctrl_i.clear) begin
        acc_d = '0;
      end
    end else if (busy_q) begin
      // The top coefficient bit carries negative weight.
      if (mplier_q[0]) begin
        if (cnt_q == svf_pkg::BIT_CNT_W'(svf_pkg::COEF_W - 1)) begin
          acc_d = acc_q - mcand_q;
        end else begin
          acc_d = acc_q + mcand_q;
        end
      end
      mplier_d = mplier_q >> 1;
      mcand_d  = mcand_q <<< 1;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == svf_pkg::BIT_CNT_W'(svf_pkg::COEF_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mplier_q <= mplier_d;
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

FILE: rtl/state_variable_filter.sv
// Top level of the trapezoidal state-variable filter.
// One sample in, one sample out. Seven products per sample run through a single
// bit-serial multiplier that retires one coefficient bit per cycle; the next
// sample is taken once the result is in the output register. Coefficients are
// Q8.24; the user must write them through the register port only while the filter
// is idle, which the block itself does not enforce. The integrators are Q9.23 and
// saturate, the output saturates to 24 bits.
`default_nettype none
`include "state_variable_filter_assert.svh"
module state_variable_filter (
  input  wire                                           clk_i,
  input  wire                                           rst_ni,
  input  wire                                           in_valid_i,
  output logic                                          in_ready_o,
  input  wire svf_pkg::svf_in_t                         in_data_i,
  output logic                                          out_valid_o,
  input  wire                                           out_ready_i,
  output svf_pkg::svf_out_t                             out_data_o,
  input  wire                                           cfg_we_i,
  input  wire logic [svf_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  wire logic [svf_pkg::COEF_W-1:0]               cfg_wdata_i
);

  localparam int SW = svf_pkg::STATE_W;
  localparam int EW = svf_pkg::EXT_W;

  svf_pkg::svf_state_e state_q, state_d;
  logic [svf_pkg::PROD_IDX_W-1:0] pidx_q, pidx_d;

  logic signed [svf_pkg::COEF_W-1:0] a1_q, a2_q, a3_q, mi_q, mb_q, ml_q;
  logic signed [SW-1:0] i1_q, i1_d, i2_q, i2_d, v1_q, v1_d, v2_q, v2_d;
  logic signed [svf_pkg::OPND_W-1:0] v3_q, v3_d;
  logic signed [svf_pkg::SAMPLE_W-1:0] v0_q, v0_d;
  logic last_q, last_d;
  logic out_valid_q, out_valid_d;
  svf_pkg::svf_out_t out_q, out_d;

  svf_pkg::svf_mac_ctrl_t mac_ctrl;
  logic signed [svf_pkg::COEF_W-1:0] mac_coef;
  logic signed [svf_pkg::OPND_W-1:0] mac_opnd;
  logic mac_busy;
  logic signed [svf_pkg::ACC_W-1:0] mac_acc;
  logic signed [EW-1:0] rnd, sum2, dbl1, dbl2;

  svf_smac u_smac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (mac_coef),
    .opnd_i (mac_opnd),
    .busy_o (mac_busy),
    .acc_o  (mac_acc)
  );

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q <= '0;
      a2_q <= '0;
      a3_q <= '0;
      mi_q <= svf_pkg::MIX_INPUT_RST;
      mb_q <= '0;
      ml_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        svf_pkg::REG_COEF_A1:   a1_q <= cfg_wdata_i;
        svf_pkg::REG_COEF_A2:   a2_q <= cfg_wdata_i;
        svf_pkg::REG_COEF_A3:   a3_q <= cfg_wdata_i;
        svf_pkg::REG_MIX_INPUT: mi_q <= cfg_wdata_i;
        svf_pkg::REG_MIX_BAND:  mb_q <= cfg_wdata_i;
        svf_pkg::REG_MIX_LOW:   ml_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Product schedule: a1*i1, a2*v3 | a2*i1, a3*v3 | mi*v0, mb*v1, ml*v2.
  always_comb begin
    case (pidx_q)
      3'd0:    begin mac_coef = a1_q; mac_opnd = svf_pkg::OPND_W'(i1_q); end
      3'd1:    begin mac_coef = a2_q; mac_opnd = v3_q; end
      3'd2:    begin mac_coef = a2_q; mac_opnd = svf_pkg::OPND_W'(i1_q); end
      3'd3:    begin mac_coef = a3_q; mac_opnd = v3_q; end
      3'd4:    begin mac_coef = mi_q; mac_opnd = svf_pkg::OPND_W'(v0_q); end
      3'd5:    begin mac_coef = mb_q; mac_opnd = svf_pkg::OPND_W'(v1_q); end
      default: begin mac_coef = ml_q; mac_opnd = svf_pkg::OPND_W'(v2_q); end
    endcase
  end

  assign rnd  = svf_pkg::round_acc(mac_acc);
  assign sum2 = EW'(i2_q) + rnd;
  assign dbl1 = (EW'(v1_q) <<< 1) - EW'(i1_q);
  assign dbl2 = (EW'(v2_q) <<< 1) - EW'(i2_q);

  always_comb begin
    state_d     = state_q;
    pidx_d      = pidx_q;
    i1_d        = i1_q;
    i2_d        = i2_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    v3_d        = v3_q;
    v0_d        = v0_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mac_ctrl    = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      svf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          v0_d    = in_data_i.sample_in;
          last_d  = in_data_i.block_last_in;
          v3_d    = svf_pkg::OPND_W'(in_data_i.sample_in) - svf_pkg::OPND_W'(i2_q);
          pidx_d  = '0;
          state_d = svf_pkg::ST_ISSUE;
        end
      end
      svf_pkg::ST_ISSUE: begin
        mac_ctrl.start = 1'b1;
        mac_ctrl.clear = (pidx_q == 3'd0) || (pidx_q == 3'd2) || (pidx_q == 3'd4);
        state_d        = svf_pkg::ST_RUN;
      end
      svf_pkg::ST_RUN: begin
        if (!mac_busy) begin
          case (pidx_q)
            3'd1:    state_d = svf_pkg::ST_V1;
            3'd3:    state_d = svf_pkg::ST_V2;
            3'd6:    state_d = svf_pkg::ST_OUT;
            default: begin
              pidx_d  = pidx_q + 1'b1;
              state_d = svf_pkg::ST_ISSUE;
            end
          endcase
        end
      end
      svf_pkg::ST_V1: begin
        v1_d    = svf_pkg::sat_state(rnd);
        pidx_d  = pidx_q + 1'b1;
        state_d = svf_pkg::ST_ISSUE;
      end
      svf_pkg::ST_V2: begin
        v2_d    = svf_pkg::sat_state(sum2);
        pidx_d  = pidx_q + 1'b1;
        state_d = svf_pkg::ST_ISSUE;
      end
      svf_pkg::ST_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d.sample_out     = svf_pkg::sat_sample(rnd);
          out_d.block_last_out = last_q;
          out_valid_d          = 1'b1;
          i1_d                 = svf_pkg::sat_state(dbl1);
          i2_d                 = svf_pkg::sat_state(dbl2);
          state_d              = svf_pkg::ST_IDLE;
        end
      end
      default: state_d = svf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svf_pkg::ST_IDLE;
      pidx_q      <= '0;
      i1_q        <= '0;
      i2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pidx_q      <= pidx_d;
      i1_q        <= i1_d;
      i2_q        <= i2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v0_q   <= v0_d;
    v1_q   <= v1_d;
    v2_q   <= v2_d;
    v3_q   <= v3_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SVF_ASSERT_NOW(a_ready_mac_idle, in_ready_o, !mac_busy)
  `SVF_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o,
                   state_q == svf_pkg::ST_ISSUE && pidx_q == '0)
  `SVF_ASSERT_NOW(a_pidx_range, state_q != svf_pkg::ST_IDLE, pidx_q <= 3'd6)
  `SVF_ASSERT_NEXT(a_out_loads,
                   state_q == svf_pkg::ST_OUT && (!out_valid_q || out_ready_i),
                   out_valid_o && state_q == svf_pkg::ST_IDLE)

endmodule
`default_nettype wire
